// ===== src/mmst_pkg.sv =====
// ---------------------------------------------------------------------------
// mmst_pkg
// Shared types, constants and helpers for the min/max segment tree block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmst_pkg;

  localparam int DEF_LEAVES = 1024;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int FIRST_W    = 10;
  localparam int END_W      = 11;
  localparam int USED_W     = 11;

  localparam logic [USED_W-1:0] USED_SIZE_RST = 11'd1024;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WR_MIN = 2'd0,
    OP_WR_MAX = 2'd1,
    OP_Q_MIN  = 2'd2,
    OP_Q_MAX  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_FOLD,
    ST_Q_STEP
  } state_t;

  // identity of the fold: nothing beats it
  function automatic logic signed [DATA_W-1:0] mmst_ident(input logic is_max);
    return is_max ? INT_MIN : INT_MAX;
  endfunction

endpackage

`default_nettype wire

// ===== src/mmst_cmp.sv =====
// ---------------------------------------------------------------------------
// mmst_cmp
// Shared signed compare unit: picks the minimum or the maximum of two words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmst_cmp
  import mmst_pkg::*;
(
  input  wire logic                     is_max,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0]      y
);

  always_comb begin
    if (is_max) begin
      y = (b > a) ? b : a;
    end else begin
      y = (b < a) ? b : a;
    end
  end

endmodule

`default_nettype wire

// ===== src/mmst_mem.sv =====
// ---------------------------------------------------------------------------
// mmst_mem
// Node store for both trees: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmst_mem
  import mmst_pkg::*;
#(
  parameter int MAW = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [MAW-1:0]           waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [MAW-1:0]           raddr,
  output logic signed [DATA_W-1:0]      rdata_r
);

  logic signed [DATA_W-1:0] mem [2**MAW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/mmst_seq.sv =====
// ---------------------------------------------------------------------------
// mmst_seq
// Sequencer: clearing pass, leaf write with ancestor update, range query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmst_seq
  import mmst_pkg::*;
#(
  parameter int LEAVES = DEF_LEAVES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [OP_W-1:0]               op,
  input  wire logic [FIRST_W-1:0]            first_index,
  input  wire logic [END_W-1:0]              end_index,
  input  wire logic signed [DATA_W-1:0]      value,
  input  wire logic [$clog2(LEAVES):0]       n_eff,
  output logic                               mem_we,
  output logic [$clog2(LEAVES)+1:0]          mem_waddr,
  output logic signed [DATA_W-1:0]           mem_wdata,
  output logic [$clog2(LEAVES)+1:0]          mem_raddr,
  input  wire logic signed [DATA_W-1:0]      mem_rdata,
  output logic                               out_strobe,
  output logic signed [DATA_W-1:0]           out_query_result
);

  localparam int AW  = $clog2(LEAVES) + 1;          // node index bits
  localparam int MAW = AW + 1;                      // tree bit + node index
  localparam int NW  = (AW + 1 > END_W + 1) ? AW + 1 : END_W + 1;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW:0]              l_r, l_nxt;
  logic [AW:0]              r_r, r_nxt;
  logic                     tree_r, tree_nxt;
  logic                     pend_r, pend_nxt;
  logic signed [DATA_W-1:0] acc_r, acc_nxt;
  logic [MAW-1:0]           clr_r, clr_nxt;
  logic                     strobe_r, strobe_nxt;
  logic signed [DATA_W-1:0] result_r, result_nxt;

  logic [NW-1:0]            first_w, end_w, n_w, end_c;
  logic [AW-1:0]            parent;
  logic signed [DATA_W-1:0] cmp_y;
  logic                     op_max;

  // single compare unit shared by the write climb and the query fold
  mmst_cmp u_cmp (
    .is_max (tree_r),
    .a      (acc_r),
    .b      (mem_rdata),
    .y      (cmp_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    tree_r   <= tree_nxt;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  always_comb begin
    first_w = NW'(first_index);
    end_w   = NW'(end_index);
    n_w     = NW'(n_eff);
    end_c   = (end_w > n_w) ? n_w : end_w;
    parent  = k_r >> 1;
    op_max  = (op_t'(op) == OP_WR_MAX) || (op_t'(op) == OP_Q_MAX);

    state_nxt  = state_r;
    k_nxt      = k_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    tree_nxt   = tree_r;
    acc_nxt    = acc_r;
    clr_nxt    = clr_r;
    pend_nxt   = 1'b0;
    strobe_nxt = 1'b0;
    result_nxt = result_r;

    mem_we    = 1'b0;
    mem_waddr = {tree_r, k_r};
    mem_wdata = acc_r;
    mem_raddr = {tree_r, k_r ^ AW'(1)};

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + MAW'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          tree_nxt = op_max;
          unique case (op_t'(op))
            OP_WR_MIN, OP_WR_MAX: begin
              // writes beyond the used size are dropped
              if (first_w < n_w) begin
                k_nxt     = AW'(first_w + n_w);
                acc_nxt   = value;
                state_nxt = ST_W_LEAF;
              end
            end
            OP_Q_MIN, OP_Q_MAX: begin
              if (first_w >= end_c) begin
                strobe_nxt = 1'b1;
                result_nxt = mmst_ident(op_max);
              end else begin
                l_nxt     = (AW+1)'(first_w + n_w);
                r_nxt     = (AW+1)'(end_c + n_w);
                acc_nxt   = mmst_ident(op_max);
                state_nxt = ST_Q_STEP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_W_LEAF: begin
        // store the leaf and fetch its sibling in the same beat
        mem_we = 1'b1;
        if (k_r == AW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_W_FOLD;
        end
      end

      ST_W_FOLD: begin
        mem_we    = 1'b1;
        mem_waddr = {tree_r, parent};
        mem_wdata = cmp_y;
        mem_raddr = {tree_r, parent ^ AW'(1)};
        acc_nxt   = cmp_y;
        k_nxt     = parent;
        if (parent == AW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_Q_STEP: begin
        // fold the word fetched last beat
        if (pend_r) begin
          acc_nxt = cmp_y;
        end
        mem_raddr = {tree_r, l_r[AW-1:0]};
        if (l_r < r_r) begin
          if (l_r[0]) begin
            pend_nxt = 1'b1;
            if (r_r[0]) begin
              l_nxt = l_r + (AW+1)'(1);
            end else begin
              l_nxt = (l_r + (AW+1)'(1)) >> 1;
              r_nxt = r_r >> 1;
            end
          end else if (r_r[0]) begin
            pend_nxt  = 1'b1;
            mem_raddr = {tree_r, r_r[AW-1:0] - AW'(1)};
            l_nxt     = l_r >> 1;
            r_nxt     = r_r >> 1;
          end else begin
            l_nxt = l_r >> 1;
            r_nxt = r_r >> 1;
          end
        end else begin
          strobe_nxt = 1'b1;
          result_nxt = pend_r ? cmp_y : acc_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_query_result = result_r;

endmodule

`default_nettype wire

// ===== src/min_max_segment_tree_top.sv =====
// ---------------------------------------------------------------------------
// min_max_segment_tree_top
// Pair of bottom-up segment trees (minimum and maximum) over signed words,
// with leaf writes and half-open range queries.
// ---------------------------------------------------------------------------
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+-------------------
//  input    | in_op, in_first_index, in_end_index,       | start & !busy
//           | in_value                                   |
//  result   | out_query_result                           | out_strobe, 1 cycle
//  config   | cfg_used_size                              | cfg_valid & cfg_ready
//
//  A write stores the leaf and then updates each tree level above it; a query
//  folds one or two nodes per level: every node goes through the single
//  memory read port and the single compare unit.
//  After reset the block clears all 2**(clog2(LEAVES)+2) nodes of both trees
//  (4096 at the default), one node per cycle; busy is high meanwhile.
//  The result side has no stall; each result shows for exactly one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_max_segment_tree_top
  import mmst_pkg::*;
#(
  parameter int LEAVES = DEF_LEAVES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_op,
  input  wire logic [FIRST_W-1:0]       in_first_index,
  input  wire logic [END_W-1:0]         in_end_index,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_strobe,
  output logic signed [DATA_W-1:0]      out_query_result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [USED_W-1:0]        cfg_used_size
);

  localparam int AW  = $clog2(LEAVES) + 1;
  localparam int MAW = AW + 1;

  logic [USED_W-1:0]        used_size_r;
  logic [AW-1:0]            n_eff;
  logic                     mem_we;
  logic [MAW-1:0]           mem_waddr;
  logic [MAW-1:0]           mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic signed [DATA_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_size_r <= USED_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      used_size_r <= cfg_used_size;
    end
  end

  // leaf offset saturates at the tree size
  always_comb begin
    if (32'(used_size_r) > LEAVES) begin
      n_eff = AW'(LEAVES);
    end else begin
      n_eff = AW'(used_size_r);
    end
  end

  mmst_seq #(
    .LEAVES (LEAVES)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .op               (in_op),
    .first_index      (in_first_index),
    .end_index        (in_end_index),
    .value            (in_value),
    .n_eff            (n_eff),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .out_strobe       (out_strobe),
    .out_query_result (out_query_result)
  );

  mmst_mem #(
    .MAW (MAW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== src/mmst_checker.sv =====
// ---------------------------------------------------------------------------
// mmst_checker
// Port-level checks on the min/max segment tree top, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmst_checker
  import mmst_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [OP_W-1:0]          in_op,
  input wire logic [FIRST_W-1:0]       in_first_index,
  input wire logic [END_W-1:0]         in_end_index,
  input wire logic                     out_strobe,
  input wire logic signed [DATA_W-1:0] out_query_result
);

  // a result only follows a query beat or the end of busy work
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) || $past(start && in_op[1]))
    else $error("result without a query");

  // a write beat is not directly followed by a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_op[1]) |=> !out_strobe)
    else $error("result after a write beat");

  // a query either answers at once or keeps the block busy
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op[1]) |=> (out_strobe || busy))
    else $error("query dropped");

  // empty min range answers with the largest value next cycle
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_Q_MIN) &&
     ({1'b0, in_first_index} >= in_end_index))
    |=> (out_strobe && (out_query_result == INT_MAX)))
    else $error("empty min query result wrong");

endmodule

bind min_max_segment_tree_top mmst_checker u_mmst_checker (.*);

`default_nettype wire
